// ===== rtl/drum_pkg.sv =====
// shared types and codes for the distinct rank uniform mapper
// no dependencies; imported by the interfaces, the top level and the bench
package drum_pkg;

    localparam int KEY_W = 32;
    localparam int REQ_W = 2;
    localparam int STAT_W = 2;

    // quotient of the scaling divide is one bit per step
    localparam int DIV_STEPS = KEY_W;
    localparam int STEP_W = $clog2(DIV_STEPS);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_STEPS - 1);

    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_PUT,
        S_DIV,
        S_DONE
    } t_state;

endpackage

// ===== rtl/drum_in_if.sv =====
// request channel: valid/ready handshake carrying req_type and value
// depends on drum_pkg
interface drum_in_if;
    import drum_pkg::*;

    logic               valid;
    logic               ready;
    logic [REQ_W-1:0]   req_type;
    logic [KEY_W-1:0]   value;

    modport source (output valid, output req_type, output value, input ready);
    modport sink   (input valid, input req_type, input value, output ready);
endinterface

// ===== rtl/drum_out_if.sv =====
// response channel: valid/ready handshake carrying mapped_value and status
// depends on drum_pkg
interface drum_out_if;
    import drum_pkg::*;

    logic               valid;
    logic               ready;
    logic [KEY_W-1:0]   mapped_value;
    logic [STAT_W-1:0]  status;

    modport source (output valid, output mapped_value, output status, input ready);
    modport sink   (input valid, input mapped_value, input status, output ready);
endinterface

// ===== rtl/distinct_rank_uniform_mapper.sv =====
// top level of the distinct rank uniform mapper
// depends on drum_pkg, drum_in_if, drum_out_if and drum_ram

// Keeps up to MAX_DISTINCT distinct 32-bit keys sorted in one ram and answers one
// response per request. Insert and lookup first run a binary search over the stored
// keys, each probe a ram read and then a compare. A new key is then put in place by
// moving the larger keys up one slot, each moved key read and then written through
// the single ram port pair, then the new key is written. A lookup that hits scales its
// rank by (2^32-1)/count in a restoring divider that reuses one subtract-compare
// unit for every quotient bit. Clear and the unused code go straight to the done
// state. One request is worked on at a time and the request channel is ready only
// while the block is idle; a finished response waits in an output register, so the
// next request can be taken before the last response is read. The key store needs
// no clearing pass after reset, since entries at or above the count are never used.
module distinct_rank_uniform_mapper #(
    parameter int MAX_DISTINCT = 1024
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    drum_in_if.sink         i_req,
    drum_out_if.source      o_rsp
);
    import drum_pkg::*;

    localparam int AW = (MAX_DISTINCT > 1) ? $clog2(MAX_DISTINCT) : 1;
    localparam int CW = $clog2(MAX_DISTINCT + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_DISTINCT);

    t_state              r_state, n_state;
    logic [REQ_W-1:0]    r_req, n_req;
    logic [KEY_W-1:0]    r_key, n_key;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_lo, n_lo;
    logic [CW-1:0]       r_hi, n_hi;
    logic                r_found, n_found;
    logic [AW-1:0]       r_idx, n_idx;
    logic [CW-1:0]       r_rem, n_rem;
    logic [KEY_W-1:0]    r_quo, n_quo;
    logic [STEP_W-1:0]   r_step, n_step;
    t_status             r_st, n_st;
    logic                r_out_valid, n_out_valid;
    logic [KEY_W-1:0]    r_out_map, n_out_map;
    t_status             r_out_st, n_out_st;

    logic                w_in_fire;
    logic                w_out_free;
    logic [CW-1:0]       w_mid;
    logic [AW-1:0]       w_idx_dec;
    logic [CW:0]         w_trial;
    logic [CW:0]         w_diff;
    logic                w_ge;
    logic [AW+KEY_W-1:0] w_num;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [KEY_W-1:0]    ram_wdata;
    logic [AW-1:0]       ram_raddr;
    logic [KEY_W-1:0]    ram_rdata;

    drum_ram #(
        .WIDTH (KEY_W),
        .DEPTH (MAX_DISTINCT)
    ) u_keys (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign w_in_fire  = i_req.valid && i_req.ready;
    assign w_out_free = !r_out_valid || o_rsp.ready;
    assign w_mid      = r_lo + ((r_hi - r_lo) >> 1);
    assign w_idx_dec  = r_idx - 1'b1;

    // shared subtract-compare unit of the restoring divider
    assign w_trial = {r_rem, r_quo[KEY_W-1]};
    assign w_diff  = w_trial - {1'b0, r_count};
    assign w_ge    = (w_trial >= {1'b0, r_count});

    // (2^32-1)*pos written as pos*2^32 - pos
    assign w_num = {r_lo[AW-1:0], {KEY_W{1'b0}}} - (AW+KEY_W)'(r_lo[AW-1:0]);

    assign i_req.ready        = (r_state == S_IDLE);
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.mapped_value = r_out_map;
    assign o_rsp.status       = r_out_st;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    if (i_req.req_type inside {REQ_INSERT, REQ_LOOKUP}) begin
                        n_state = S_SEARCH;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SEARCH: begin
                if (r_lo != r_hi) begin
                    n_state = S_CMP;
                end else if (r_req == REQ_LOOKUP) begin
                    n_state = r_found ? S_DIV : S_DONE;
                end else if (r_found || (r_count >= MAX_CNT)) begin
                    n_state = S_DONE;
                end else if (r_count > r_lo) begin
                    n_state = S_SHIFT_RD;
                end else begin
                    n_state = S_PUT;
                end
            end
            S_CMP:      n_state = S_SEARCH;
            S_SHIFT_RD: n_state = S_SHIFT_WR;
            S_SHIFT_WR: begin
                n_state = (CW'(w_idx_dec) > r_lo) ? S_SHIFT_RD : S_PUT;
            end
            S_PUT:      n_state = S_DONE;
            S_DIV: begin
                if (r_step == STEP_LAST) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:    n_state = S_IDLE;
        endcase
    end

    // datapath and ram control
    always_comb begin
        n_req       = r_req;
        n_key       = r_key;
        n_count     = r_count;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_found     = r_found;
        n_idx       = r_idx;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_step      = r_step;
        n_st        = r_st;
        n_out_valid = r_out_valid;
        n_out_map   = r_out_map;
        n_out_st    = r_out_st;
        ram_we      = 1'b0;
        ram_waddr   = r_idx;
        ram_wdata   = ram_rdata;
        ram_raddr   = w_mid[AW-1:0];

        if (o_rsp.valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    n_req   = i_req.req_type;
                    n_key   = i_req.value;
                    n_lo    = '0;
                    n_hi    = r_count;
                    n_found = 1'b0;
                    n_quo   = '0;
                    n_st    = ST_OK;
                    if (i_req.req_type == REQ_CLEAR) begin
                        n_count = '0;
                    end
                end
            end
            S_SEARCH: begin
                if (r_lo == r_hi) begin
                    if (r_req == REQ_LOOKUP) begin
                        if (r_found) begin
                            n_rem  = CW'(w_num[AW+KEY_W-1:KEY_W]);
                            n_quo  = w_num[KEY_W-1:0];
                            n_step = '0;
                        end else begin
                            n_st = ST_NOT_FOUND;
                        end
                    end else begin
                        if (!r_found && (r_count >= MAX_CNT)) begin
                            n_st = ST_FULL;
                        end
                        n_idx = r_count[AW-1:0];
                    end
                end
            end
            S_CMP: begin
                // lower bound: a probe equal to the key is the final position
                if (ram_rdata < r_key) begin
                    n_lo = w_mid + 1'b1;
                end else begin
                    n_hi = w_mid;
                end
                if (ram_rdata == r_key) begin
                    n_found = 1'b1;
                end
            end
            S_SHIFT_RD: begin
                ram_raddr = w_idx_dec;
            end
            S_SHIFT_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_idx;
                ram_wdata = ram_rdata;
                n_idx     = w_idx_dec;
            end
            S_PUT: begin
                ram_we    = 1'b1;
                ram_waddr = r_lo[AW-1:0];
                ram_wdata = r_key;
                n_count   = r_count + 1'b1;
            end
            S_DIV: begin
                n_rem  = w_ge ? w_diff[CW-1:0] : w_trial[CW-1:0];
                n_quo  = {r_quo[KEY_W-2:0], w_ge};
                n_step = r_step + 1'b1;
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_map   = r_quo;
                    n_out_st    = r_st;
                end
            end
            default: begin
                n_out_valid = r_out_valid;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req     <= n_req;
        r_key     <= n_key;
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_found   <= n_found;
        r_idx     <= n_idx;
        r_rem     <= n_rem;
        r_quo     <= n_quo;
        r_step    <= n_step;
        r_st      <= n_st;
        r_out_map <= n_out_map;
        r_out_st  <= n_out_st;
    end

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MAX_CNT)
        else $error("stored key count above capacity");

    a_search_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH || r_state == S_CMP) |-> (r_lo <= r_hi && r_hi <= r_count))
        else $error("binary search window out of range");

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_count))
        else $error("divider remainder not below divisor");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |-> (r_count == $past(r_count) + 1'b1 || r_count == '0))
        else $error("key count changed other than by insert or clear");
endmodule

// ===== rtl/drum_ram.sv =====
// generic single write port, single read port ram with registered read data
// no dependencies
module drum_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== tb/distinct_rank_uniform_mapper_test.sv =====
// self-checking bench for distinct_rank_uniform_mapper: a directed table, then random request mixes
// depends on drum_pkg, drum_in_if, drum_out_if and the rtl top level
// expected responses come from a local sorted-set model of the rank mapping
module distinct_rank_uniform_mapper_test;
    timeunit 1ns;
    timeprecision 1ps;

    import drum_pkg::*;

    localparam int MAX_DISTINCT = 1024;
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam logic [63:0] FULL_SCALE = 64'h0000_0000_FFFF_FFFF;
    localparam int ITEM_TARGET = 1520;
    localparam int FILL_AFTER = 300;
    localparam int PHASE_LEN = 97;
    localparam int LONG_HOLD = 300;
    localparam int DRAIN_CYCLES = 200;

    typedef struct {
        logic [KEY_W-1:0] mapped;
        t_status          st;
    } t_rsp;

    typedef struct {
        logic [REQ_W-1:0] req;
        logic [KEY_W-1:0] key;
        bit               fixed;
        logic [KEY_W-1:0] mapped;
        t_status          st;
    } t_dir_row;

    // fixed rows carry their expected response, the others go through the model
    t_dir_row directed_rows [0:22] = '{
        '{REQ_LOOKUP, 32'h0000_0000, 1'b1, 32'h0, ST_NOT_FOUND}, // empty set
        '{REQ_INSERT, 32'hFFFF_FFFF, 1'b1, 32'h0, ST_OK},
        '{REQ_LOOKUP, 32'hFFFF_FFFF, 1'b1, 32'h0, ST_OK},        // sole key has rank 0
        '{REQ_INSERT, 32'h0000_0000, 1'b1, 32'h0, ST_OK},
        '{REQ_LOOKUP, 32'hFFFF_FFFF, 1'b0, 32'h0, ST_OK},
        '{REQ_LOOKUP, 32'h0000_0000, 1'b1, 32'h0, ST_OK},
        '{REQ_INSERT, 32'h0000_0000, 1'b1, 32'h0, ST_OK},        // duplicate
        '{REQ_LOOKUP, 32'h0000_0001, 1'b1, 32'h0, ST_NOT_FOUND},
        '{REQ_INSERT, 32'h8000_0000, 1'b1, 32'h0, ST_OK},
        '{REQ_LOOKUP, 32'h8000_0000, 1'b0, 32'h0, ST_OK},
        '{REQ_LOOKUP, 32'hFFFF_FFFE, 1'b1, 32'h0, ST_NOT_FOUND},
        '{REQ_UNUSED, 32'hFFFF_FFFF, 1'b1, 32'h0, ST_OK},
        '{REQ_INSERT, 32'h7FFF_FFFF, 1'b1, 32'h0, ST_OK},
        '{REQ_LOOKUP, 32'hFFFF_FFFF, 1'b0, 32'h0, ST_OK},
        '{REQ_LOOKUP, 32'h7FFF_FFFF, 1'b0, 32'h0, ST_OK},
        '{REQ_CLEAR,  32'hFFFF_FFFF, 1'b1, 32'h0, ST_OK},
        '{REQ_LOOKUP, 32'h0000_0000, 1'b1, 32'h0, ST_NOT_FOUND}, // empty after clear
        '{REQ_UNUSED, 32'h0000_0000, 1'b1, 32'h0, ST_OK},
        '{REQ_INSERT, 32'h5555_5555, 1'b1, 32'h0, ST_OK},
        '{REQ_INSERT, 32'hAAAA_AAAA, 1'b1, 32'h0, ST_OK},
        '{REQ_LOOKUP, 32'hAAAA_AAAA, 1'b0, 32'h0, ST_OK},
        '{REQ_LOOKUP, 32'h5555_5555, 1'b1, 32'h0, ST_OK},
        '{REQ_CLEAR,  32'h0000_0000, 1'b1, 32'h0, ST_OK}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    drum_in_if  req_ch ();
    drum_out_if rsp_ch ();

    distinct_rank_uniform_mapper #(
        .MAX_DISTINCT (MAX_DISTINCT)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    logic [KEY_W-1:0] known_keys [$];
    t_rsp             awaited_rsp [$];
    int unsigned      mismatches = 0;
    int unsigned      items_sent = 0;
    int unsigned      sender_idle_pct = 0;
    int unsigned      rcv_stall_pct = 0;
    int unsigned      holds_wanted = 0;
    int unsigned      holds_served = 0;
    int unsigned      hold_left = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int unsigned keys_below(input logic [KEY_W-1:0] key);
        int unsigned lo, hi, mid;
        lo = 0;
        hi = known_keys.size();
        while (lo < hi) begin
            mid = lo + ((hi - lo) >> 1);
            if (known_keys[mid] < key) lo = mid + 1;
            else hi = mid;
        end
        return lo;
    endfunction

    // applies one request to the local key set and gives the response it causes
    function automatic void rank_map(input logic [REQ_W-1:0] req, input logic [KEY_W-1:0] key,
                                     output logic [KEY_W-1:0] mapped, output t_status st);
        int unsigned pos;
        bit          hit;
        logic [63:0] scaled;
        mapped = '0;
        st = ST_OK;
        pos = keys_below(key);
        hit = (pos < known_keys.size()) && (known_keys[pos] == key);
        if (req == REQ_INSERT) begin
            if (!hit) begin
                if (known_keys.size() >= MAX_DISTINCT) st = ST_FULL;
                else known_keys.insert(pos, key);
            end
        end else if (req == REQ_LOOKUP) begin
            if (hit) begin
                scaled = FULL_SCALE * 64'(pos);
                mapped = KEY_W'(scaled / 64'(known_keys.size()));
            end else begin
                st = ST_NOT_FOUND;
            end
        end else if (req == REQ_CLEAR) begin
            known_keys.delete();
        end
    endfunction

    function automatic logic [KEY_W-1:0] pick_stored();
        if (known_keys.size() == 0) return $urandom;
        return known_keys[$urandom_range(known_keys.size() - 1)];
    endfunction

    function automatic logic [KEY_W-1:0] pick_neighbor();
        logic [KEY_W-1:0] k;
        k = pick_stored();
        return $urandom_range(1) ? k + 32'd1 : k - 32'd1;
    endfunction

    function automatic logic [KEY_W-1:0] pick_extreme();
        case ($urandom_range(3))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h7FFF_FFFF;
            default: return 32'h8000_0000;
        endcase
    endfunction

    // one request transaction; the expectation is recorded when it is accepted
    task automatic offer(input logic [REQ_W-1:0] req, input logic [KEY_W-1:0] key,
                         input bit fixed = 1'b0, input logic [KEY_W-1:0] fx_mapped = '0,
                         input t_status fx_st = ST_OK);
        t_rsp             want;
        logic [KEY_W-1:0] m;
        t_status          s;
        if ($urandom_range(99) < sender_idle_pct) begin
            req_ch.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < sender_idle_pct);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= req;
        req_ch.value    <= key;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        rank_map(req, key, m, s);
        want.mapped = fixed ? fx_mapped : m;
        want.st     = fixed ? fx_st : s;
        awaited_rsp.push_back(want);
        items_sent++;
    endtask

    // sender goes quiet until every response is back
    task automatic drain_responses();
        req_ch.valid <= 1'b0;
        do @(posedge i_clk); while (awaited_rsp.size() != 0);
    endtask

    task automatic pick_idling();
        case ((items_sent / PHASE_LEN) % 4)
            0: begin sender_idle_pct = 0;  rcv_stall_pct = 0;  end
            1: begin sender_idle_pct = 75; rcv_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  rcv_stall_pct = 75; end
            default: begin sender_idle_pct = 10; rcv_stall_pct = 10; end
        endcase
    endtask

    task automatic random_request();
        int unsigned roll, kroll;
        logic [KEY_W-1:0] key;
        pick_idling();
        roll = $urandom_range(99);
        kroll = $urandom_range(99);
        if (roll < 2) begin
            offer(REQ_CLEAR, $urandom);
        end else if (roll < 5) begin
            offer(REQ_UNUSED, $urandom);
        end else if (roll < 50) begin
            if (kroll < 55) key = $urandom;
            else if (kroll < 75) key = pick_neighbor();
            else if (kroll < 88) key = pick_stored();
            else key = pick_extreme();
            offer(REQ_INSERT, key);
        end else begin
            if (kroll < 65) key = pick_stored();
            else if (kroll < 85) key = pick_neighbor();
            else key = $urandom;
            offer(REQ_LOOKUP, key);
        end
    endtask

    // back-to-back inserts and lookups for the hold-off stretch
    task automatic random_request_no_idle();
        if ($urandom_range(1)) offer(REQ_INSERT, $urandom);
        else offer(REQ_LOOKUP, pick_stored());
    endtask

    // mostly ascending inserts keep the fill cheap; a few land in the middle
    task automatic fill_table();
        logic [KEY_W-1:0] next_key;
        int unsigned roll;
        pick_idling();
        offer(REQ_CLEAR, $urandom);
        next_key = $urandom_range(1, 1 << 20);
        while (known_keys.size() < MAX_DISTINCT) begin
            pick_idling();
            roll = $urandom_range(99);
            if (roll < 3) begin
                offer(REQ_LOOKUP, pick_stored());
            end else if (roll < 5) begin
                offer(REQ_INSERT, pick_stored());
            end else if (roll < 6 && known_keys.size() != 0) begin
                offer(REQ_INSERT, $urandom_range(known_keys[$]));
            end else begin
                offer(REQ_INSERT, next_key);
                next_key += $urandom_range(1, 1 << 21);
            end
        end
        // full set: new keys are dropped, duplicates still pass
        offer(REQ_INSERT, 32'hFFFF_FFFF);
        offer(REQ_INSERT, pick_neighbor());
        offer(REQ_INSERT, pick_stored());
        offer(REQ_LOOKUP, known_keys[$]);
        offer(REQ_LOOKUP, known_keys[0]);
        offer(REQ_LOOKUP, 32'hFFFF_FFFF);
        repeat (10) offer(REQ_LOOKUP, pick_stored());
        repeat (5) offer(REQ_INSERT, $urandom);
        offer(REQ_CLEAR, $urandom);
    endtask

    task automatic random_episodes(input int unsigned until_items);
        int unsigned set_n;
        while (items_sent < until_items) begin
            set_n = ($urandom_range(19) == 0) ? $urandom_range(41, 160) : $urandom_range(1, 40);
            pick_idling();
            if ($urandom_range(9) != 0) offer(REQ_CLEAR, $urandom);
            repeat (2 * set_n + $urandom_range(8)) random_request();
        end
    endtask

    // response side: random stalls, plus long hold-offs on request
    initial begin
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left == 0 && holds_served != holds_wanted) begin
                hold_left = LONG_HOLD;
                holds_served++;
            end
            if (hold_left != 0) begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= ($urandom_range(99) >= rcv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            if (awaited_rsp.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("response with nothing pending: mapped %h status %0d",
                             rsp_ch.mapped_value, rsp_ch.status);
            end else begin
                want = awaited_rsp.pop_front();
                if (rsp_ch.mapped_value !== want.mapped || rsp_ch.status !== want.st) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected mapped %h status %0d, got mapped %h status %0d",
                                 want.mapped, want.st, rsp_ch.mapped_value, rsp_ch.status);
                end
            end
        end
    end

    initial begin
        #50ms;
        $display("distinct_rank_uniform_mapper test failed");
        $finish;
    end

    initial begin
        i_rst_n         <= 1'b0;
        req_ch.valid    <= 1'b0;
        req_ch.req_type <= REQ_INSERT;
        req_ch.value    <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i])
            offer(directed_rows[i].req, directed_rows[i].key, directed_rows[i].fixed,
                  directed_rows[i].mapped, directed_rows[i].st);
        drain_responses();

        // receiver holds off while the sender keeps pushing, so the input backs up
        sender_idle_pct = 0;
        rcv_stall_pct = 0;
        holds_wanted++;
        repeat (10) random_request_no_idle();
        drain_responses();

        random_episodes(FILL_AFTER);
        fill_table();
        random_episodes(ITEM_TARGET);

        drain_responses();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && awaited_rsp.size() == 0) begin
            $display("distinct_rank_uniform_mapper test passed");
        end else begin
            $display("distinct_rank_uniform_mapper test failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/drum_pkg.sv
rtl/drum_in_if.sv
rtl/drum_out_if.sv
rtl/drum_ram.sv
rtl/distinct_rank_uniform_mapper.sv
tb/distinct_rank_uniform_mapper_test.sv
